>>> rtl/gsww_pkg.sv
// Package for the glyph strip scanner and word-wrap measurer.
// Holds the request action codes, field widths and the structs passed to and from the text stage.
// Depends on nothing.
package gsww_pkg;

    typedef enum logic [1:0] {
        ACT_ORDER  = 2'd0,
        ACT_COLUMN = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    localparam logic [1:0] REG_SPACING = 2'd0;
    localparam logic [1:0] REG_SCALE   = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    localparam int CODE_W    = 8;
    localparam int GLYPH_W   = 12;
    localparam int SPACING_W = 8;
    localparam int SCALE_W   = 5;
    localparam int LIMIT_W   = 24;
    localparam int ADV_W     = 20;
    localparam int SUM_W     = 32;
    localparam int POS_W     = 16;

    localparam logic [GLYPH_W-1:0] GLYPH_MAX  = 12'hFFF;
    localparam logic [CODE_W-1:0]  CHAN_FULL  = 8'hFF;
    localparam logic [CODE_W-1:0]  CHAN_NONE  = 8'h00;
    localparam logic [CODE_W-1:0]  SPACE_CODE = 8'h20;

    typedef struct packed {
        logic                    valid;
        logic signed [ADV_W-1:0] adv;
        logic                    is_space;
        logic                    last;
    } text_item_t;

    typedef struct packed {
        logic [POS_W-1:0]        break_position;
        logic                    broke_early;
        logic signed [SUM_W-1:0] text_width;
    } text_result_t;

endpackage

>>> rtl/glyph_strip_word_wrap.sv
// Top level of the glyph strip scanner and greedy word-wrap measurer.
// Depends on gsww_pkg and instantiates gsww_text for the accumulation stage.
//
// One request is taken in every cycle when the result side keeps up. A request passes
// through the first-stage registers, which also take the reads of the glyph width and
// order-code memories, then the scan state and second-stage registers, which take the scan
// update and advance multiply, and then the output register, which takes the width
// accumulation and offers the result. A waiting result stalls the pipe only when the stage
// behind it also holds a result. The known-code bits sit in flops and clear at once, so
// there is no clearing pass after reset.
module glyph_strip_word_wrap
    import gsww_pkg::*;
#(
    parameter int MAX_GLYPHS      = 128,
    parameter int MAX_COLUMNS     = 4096,
    parameter int CODE_SPACE      = 256,
    parameter int TEXT_INDEX_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [1:0]              action,
    input  logic [CODE_W-1:0]       glyph_order_code,
    input  logic [7:0]              pixel_red,
    input  logic [7:0]              pixel_green,
    input  logic [7:0]              pixel_blue,
    input  logic [7:0]              pixel_alpha,
    input  logic [CODE_W-1:0]       text_char,
    input  logic                    text_last,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    result_kind,
    output logic [CODE_W-1:0]       glyph_code,
    output logic [GLYPH_W-1:0]      glyph_width,
    output logic [POS_W-1:0]        break_position,
    output logic                    broke_early,
    output logic signed [SUM_W-1:0] text_width
);

    localparam int OC_W  = $clog2(MAX_GLYPHS + 1);
    localparam int OG_AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int DW    = (COL_W > GLYPH_W) ? COL_W : GLYPH_W;
    localparam int CS_AW = $clog2(CODE_SPACE);

    logic signed [SPACING_W-1:0] spacing_reg;
    logic [SCALE_W-1:0]          scale_reg;
    logic [LIMIT_W-1:0]          limit_reg;

    logic [GLYPH_W-1:0] width_mem [CODE_SPACE];
    logic [CODE_W-1:0]  order_mem [MAX_GLYPHS];
    logic [GLYPH_W-1:0] width_rd_reg;
    logic [CODE_W-1:0]  order_rd_reg;

    logic [OC_W-1:0]       order_count_reg, order_count_next;
    logic [OC_W-1:0]       order_next_reg, order_next_next;
    logic                  started_reg, started_next;
    logic [COL_W-1:0]      prev_reg, prev_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [CODE_SPACE-1:0] known_reg, known_next;

    logic                  p1_valid_reg;
    action_t               p1_action_reg;
    logic [CODE_W-1:0]     p1_code_reg;
    logic                  p1_marker_reg;
    logic [CODE_W-1:0]     p1_char_reg;
    logic                  p1_last_reg;
    logic                  fwd_w_hit_reg;
    logic [GLYPH_W-1:0]    fwd_w_data_reg;
    logic                  fwd_o_hit_reg;
    logic [CODE_W-1:0]     fwd_o_data_reg;

    logic                  p2_glyph_reg;
    logic [CODE_W-1:0]     p2_code_reg;
    logic [GLYPH_W-1:0]    p2_width_reg;
    text_item_t            p2_text_reg;
    text_item_t            p2_text_next;
    text_result_t          text_res;

    logic                  rsp_valid_reg;
    logic                  kind_reg;
    logic [CODE_W-1:0]     code_out_reg;
    logic [GLYPH_W-1:0]    width_out_reg;
    logic [POS_W-1:0]      pos_out_reg;
    logic                  broke_out_reg;
    logic signed [SUM_W-1:0] sum_out_reg;

    logic                  advance;
    logic                  p2_result;
    logic                  cfg_write;
    logic                  in_marker;
    logic                  order_we;
    logic                  width_we;
    logic                  glyph_hit;
    logic [CODE_W-1:0]     order_code;
    logic [GLYPH_W-1:0]    stored_w;
    logic [DW-1:0]         diff;
    logic [GLYPH_W-1:0]    gw;
    logic                  code_in_space;
    logic                  char_known;
    logic signed [ADV_W-1:0] base_x;
    logic signed [ADV_W-1:0] scale_x;
    logic [CS_AW-1:0]      width_wa;
    logic [CS_AW-1:0]      width_ra;
    logic [OG_AW-1:0]      order_wa;
    logic [OG_AW-1:0]      order_ra;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= '0;
            scale_reg <= SCALE_W'(1);
            limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SPACING: spacing_reg <= pwdata[SPACING_W-1:0];
                REG_SCALE:   scale_reg <= pwdata[SCALE_W-1:0];
                REG_LIMIT:   limit_reg <= pwdata[LIMIT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SPACING: prdata = {{(32 - SPACING_W){1'b0}}, spacing_reg};
            REG_SCALE:   prdata = {{(32 - SCALE_W){1'b0}}, scale_reg};
            REG_LIMIT:   prdata = {{(32 - LIMIT_W){1'b0}}, limit_reg};
            default:     prdata = '0;
        endcase
    end

    assign p2_result = p2_glyph_reg || (p2_text_reg.valid && p2_text_reg.last);
    assign advance = !p2_result || !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;

    assign in_marker = (pixel_red == CHAN_FULL) && (pixel_green == CHAN_NONE)
                    && (pixel_blue == CHAN_FULL) && (pixel_alpha == CHAN_FULL);

    always_comb
    begin
        order_code = fwd_o_hit_reg ? fwd_o_data_reg : order_rd_reg;
        stored_w = fwd_w_hit_reg ? fwd_w_data_reg : width_rd_reg;
        diff = DW'(col_reg) - DW'(prev_reg) - DW'(1);
        gw = (diff > DW'(GLYPH_MAX)) ? GLYPH_MAX : GLYPH_W'(diff);
        code_in_space = {1'b0, order_code} < (CODE_W + 1)'(CODE_SPACE);
        char_known = ({1'b0, p1_char_reg} < (CODE_W + 1)'(CODE_SPACE))
                  && known_reg[p1_char_reg[CS_AW-1:0]];
        base_x = ADV_W'($signed({1'b0, stored_w}))
               + ADV_W'(spacing_reg);
        scale_x = $signed({{(ADV_W - SCALE_W){1'b0}}, scale_reg});
        width_wa = order_code[CS_AW-1:0];
        order_wa = order_count_reg[OG_AW-1:0];

        order_count_next = order_count_reg;
        order_next_next = order_next_reg;
        started_next = started_reg;
        prev_next = prev_reg;
        col_next = col_reg;
        known_next = known_reg;
        order_we = 1'b0;
        width_we = 1'b0;
        glyph_hit = 1'b0;

        if (p1_valid_reg)
        begin
            unique case (p1_action_reg)
                ACT_ORDER:
                begin
                    if (order_count_reg < OC_W'(MAX_GLYPHS))
                    begin
                        order_we = 1'b1;
                        order_count_next = order_count_reg + 1'b1;
                    end
                end
                ACT_COLUMN:
                begin
                    if (col_reg < COL_W'(MAX_COLUMNS)
                        && !(started_reg && order_next_reg >= order_count_reg))
                    begin
                        col_next = col_reg + 1'b1;
                        if (p1_marker_reg)
                        begin
                            prev_next = col_reg;
                            if (!started_reg)
                            begin
                                started_next = 1'b1;
                            end
                            else
                            begin
                                glyph_hit = 1'b1;
                                order_next_next = order_next_reg + 1'b1;
                                if (code_in_space && !known_reg[width_wa])
                                begin
                                    known_next[width_wa] = 1'b1;
                                    width_we = 1'b1;
                                end
                            end
                        end
                    end
                end
                ACT_TEXT:
                begin
                end
                ACT_CLEAR:
                begin
                    order_count_next = '0;
                    order_next_next = '0;
                    started_next = 1'b0;
                    prev_next = '0;
                    col_next = '0;
                    known_next = '0;
                end
            endcase
        end

        width_ra = text_char[CS_AW-1:0];
        order_ra = order_next_next[OG_AW-1:0];

        p2_text_next.valid = p1_valid_reg && (p1_action_reg == ACT_TEXT);
        p2_text_next.adv = char_known ? base_x * scale_x : '0;
        p2_text_next.is_space = (p1_char_reg == SPACE_CODE);
        p2_text_next.last = p1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && width_we)
        begin
            width_mem[width_wa] <= gw;
        end
        if (advance)
        begin
            width_rd_reg <= width_mem[width_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && order_we)
        begin
            order_mem[order_wa] <= p1_code_reg;
        end
        if (advance)
        begin
            order_rd_reg <= order_mem[order_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_count_reg <= '0;
            order_next_reg <= '0;
            started_reg <= 1'b0;
            prev_reg <= '0;
            col_reg <= '0;
            known_reg <= '0;
            p1_valid_reg <= 1'b0;
            fwd_w_hit_reg <= 1'b0;
            fwd_o_hit_reg <= 1'b0;
            p2_glyph_reg <= 1'b0;
            p2_text_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                order_count_reg <= order_count_next;
                order_next_reg <= order_next_next;
                started_reg <= started_next;
                prev_reg <= prev_next;
                col_reg <= col_next;
                known_reg <= known_next;
                p1_valid_reg <= req_valid;
                fwd_w_hit_reg <= width_we && (width_wa == width_ra);
                fwd_o_hit_reg <= order_we && (order_wa == order_ra);
                p2_glyph_reg <= glyph_hit;
                p2_text_reg <= p2_text_next;
            end
            if (advance && p2_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_action_reg <= action_t'(action);
            p1_code_reg <= glyph_order_code;
            p1_marker_reg <= in_marker;
            p1_char_reg <= text_char;
            p1_last_reg <= text_last;
            fwd_w_data_reg <= gw;
            fwd_o_data_reg <= p1_code_reg;
            p2_code_reg <= order_code;
            p2_width_reg <= gw;
        end
        if (advance && p2_result)
        begin
            if (p2_glyph_reg)
            begin
                kind_reg <= KIND_GLYPH;
                code_out_reg <= p2_code_reg;
                width_out_reg <= p2_width_reg;
                pos_out_reg <= '0;
                broke_out_reg <= 1'b0;
                sum_out_reg <= '0;
            end
            else
            begin
                kind_reg <= KIND_TEXT;
                code_out_reg <= '0;
                width_out_reg <= '0;
                pos_out_reg <= text_res.break_position;
                broke_out_reg <= text_res.broke_early;
                sum_out_reg <= text_res.text_width;
            end
        end
    end

    gsww_text #(
        .TEXT_INDEX_BITS(TEXT_INDEX_BITS)
    ) u_text (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .item      (p2_text_reg),
        .line_limit(limit_reg),
        .result    (text_res)
    );

    assign rsp_valid = rsp_valid_reg;
    assign result_kind = kind_reg;
    assign glyph_code = code_out_reg;
    assign glyph_width = width_out_reg;
    assign break_position = pos_out_reg;
    assign broke_early = broke_out_reg;
    assign text_width = sum_out_reg;

    a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
        order_next_reg <= order_count_reg)
        else $error("Glyph assignment has run past the loaded order list.");

    a_glyph_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_hit |-> started_reg)
        else $error("A glyph closed before the first marker was seen.");

    a_marker_order: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (prev_reg < col_reg))
        else $error("The previous marker does not lie behind the current column.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready && p2_result) |-> !req_ready)
        else $error("A request was taken while a pending result had nowhere to go.");

endmodule

>>> rtl/gsww_text.sv
// Text accumulation stage: running width, word-start tracking and greedy break decision.
// Depends on gsww_pkg for the text item and result structs.
module gsww_text
    import gsww_pkg::*;
#(
    parameter int TEXT_INDEX_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  text_item_t         item,
    input  logic [LIMIT_W-1:0] line_limit,
    output text_result_t       result
);

    logic [SUM_W-1:0]           line_sum_reg, line_sum_next;
    logic [TEXT_INDEX_BITS-1:0] char_pos_reg, char_pos_next;
    logic [TEXT_INDEX_BITS-1:0] word_start_reg, word_start_next;
    logic [TEXT_INDEX_BITS-1:0] break_index_reg, break_index_next;
    logic                       seen_reg, seen_next;
    logic                       prior_space_reg, prior_space_next;
    logic                       broke_reg, broke_next;
    logic signed [SUM_W:0]      total;
    logic [SUM_W-1:0]           sum_new;
    logic [TEXT_INDEX_BITS-1:0] pos_new;
    logic [TEXT_INDEX_BITS-1:0] idx_new;
    logic                       broke_new;

    always_comb
    begin
        total = $signed({line_sum_reg[SUM_W-1], line_sum_reg})
              + $signed({{(SUM_W + 1 - ADV_W){item.adv[ADV_W-1]}}, item.adv});
        sum_new = total[SUM_W-1:0];
        pos_new = (&char_pos_reg) ? char_pos_reg : char_pos_reg + 1'b1;
        broke_new = broke_reg;
        idx_new = break_index_reg;
        word_start_next = word_start_reg;
        seen_next = seen_reg;
        if (!broke_reg && !item.is_space)
        begin
            if (total > $signed({{(SUM_W + 1 - LIMIT_W){1'b0}}, line_limit}) && seen_reg)
            begin
                broke_new = 1'b1;
                idx_new = word_start_reg;
            end
            else if (prior_space_reg)
            begin
                word_start_next = char_pos_reg;
                seen_next = 1'b1;
            end
        end
        result.break_position = broke_new ? POS_W'(idx_new) : POS_W'(pos_new);
        result.broke_early = broke_new;
        result.text_width = $signed(sum_new);
        if (item.last)
        begin
            line_sum_next = '0;
            char_pos_next = '0;
            word_start_next = '0;
            seen_next = 1'b0;
            prior_space_next = 1'b0;
            broke_next = 1'b0;
            break_index_next = '0;
        end
        else
        begin
            line_sum_next = sum_new;
            char_pos_next = pos_new;
            prior_space_next = item.is_space;
            broke_next = broke_new;
            break_index_next = idx_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_sum_reg <= '0;
            char_pos_reg <= '0;
            word_start_reg <= '0;
            break_index_reg <= '0;
            seen_reg <= 1'b0;
            prior_space_reg <= 1'b0;
            broke_reg <= 1'b0;
        end
        else if (en && item.valid)
        begin
            line_sum_reg <= line_sum_next;
            char_pos_reg <= char_pos_next;
            word_start_reg <= word_start_next;
            break_index_reg <= break_index_next;
            seen_reg <= seen_next;
            prior_space_reg <= prior_space_next;
            broke_reg <= broke_next;
        end
    end

endmodule
